FILE: rtl/vtpd_pkg.sv
// package for the vertex transform and perspective divide unit
// holds request types, matrix type, register codes and fixed-point constants
// no dependencies
package vtpd_pkg;

  localparam int NUM_REGS  = 8;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;
  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int DOT_W     = SUM_W - FRAC_BITS;
  localparam int REM_W     = DOT_W + 1;
  localparam int QUO_W     = FRAC_BITS + 17;
  localparam int LANES     = 3;
  localparam int NEAR_ZERO = 66;

  localparam logic [2:0] REG_ROW0_COLS01 = 3'd0;
  localparam logic [2:0] REG_ROW0_COLS23 = 3'd1;
  localparam logic [2:0] REG_ROW1_COLS01 = 3'd2;
  localparam logic [2:0] REG_ROW1_COLS23 = 3'd3;
  localparam logic [2:0] REG_ROW2_COLS01 = 3'd4;
  localparam logic [2:0] REG_ROW2_COLS23 = 3'd5;
  localparam logic [2:0] REG_ROW3_COLS01 = 3'd6;
  localparam logic [2:0] REG_ROW3_COLS23 = 3'd7;

  localparam logic [DATA_W-1:0] ONE_LO = 64'h0000_0000_0001_0000;
  localparam logic [DATA_W-1:0] ONE_HI = 64'h0001_0000_0000_0000;

  typedef struct packed {
    logic                      func;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
    logic signed [COORD_W-1:0] in_w;
  } in_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      divided;
    logic                      saturated;
  } out_req_t;

  typedef logic [3:0][3:0][COORD_W-1:0] mat_t;

  typedef struct packed {
    logic                  func;
    logic [3:0][DOT_W-1:0] dot;
  } dot_res_t;

  typedef struct packed {
    logic                        div;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0]            ovf;
    logic [LANES-1:0][COORD_W-1:0] clamp_val;
    logic [LANES-1:0]            clamp_sat;
  } div_ctl_t;

  function automatic logic [DATA_W-1:0] reg_reset(logic [2:0] idx);
    logic [DATA_W-1:0] val;
    unique case (idx)
      REG_ROW0_COLS01: val = ONE_LO;
      REG_ROW1_COLS01: val = ONE_HI;
      REG_ROW2_COLS23: val = ONE_LO;
      REG_ROW3_COLS23: val = ONE_HI;
      default:         val = '0;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/vtpd_cfg_regs.sv
// apb-style matrix register file, eight 64-bit registers at 8-byte spacing
// depends on vtpd_pkg
module vtpd_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vtpd_pkg::ADDR_W-1:0]  paddr,
  input  logic [vtpd_pkg::DATA_W-1:0]  pwdata,
  output logic [vtpd_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output vtpd_pkg::mat_t               mat
);
  import vtpd_pkg::*;

  logic [DATA_W-1:0] regs_r [NUM_REGS];
  logic [2:0]        idx;
  logic              wr_en;

  assign idx    = paddr[ADDR_W-1:3];
  assign wr_en  = psel & penable & pwrite;
  assign prdata = regs_r[idx];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= reg_reset(3'(i));
      end
    end else if (wr_en) begin
      regs_r[idx] <= pwdata;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (c % 2 == 1) begin
          mat[r][c] = regs_r[r * 2 + c / 2][DATA_W-1:COORD_W];
        end else begin
          mat[r][c] = regs_r[r * 2 + c / 2][COORD_W-1:0];
        end
      end
    end
  end

endmodule

FILE: rtl/vtpd_dot.sv
// two-stage dot product: sixteen registered products, then rounded column sums
// depends on vtpd_pkg
module vtpd_dot (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  vtpd_pkg::in_req_t  in_data,
  input  vtpd_pkg::mat_t     mat,
  output logic               dot_valid,
  output vtpd_pkg::dot_res_t dot_res
);
  import vtpd_pkg::*;

  localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) <<< (FRAC_BITS - 1);

  logic signed [COORD_W-1:0] vin [4];
  logic signed [PROD_W-1:0]  prod_nxt [4][4];
  logic signed [PROD_W-1:0]  prod_r [4][4];
  logic signed [SUM_W-1:0]   sum_c [4];
  logic                      func_r;
  logic                      valid_a_r;
  logic                      valid_b_r;
  dot_res_t                  res_nxt;
  dot_res_t                  res_r;

  assign vin[0] = in_data.in_x;
  assign vin[1] = in_data.in_y;
  assign vin[2] = in_data.in_z;
  assign vin[3] = in_data.in_w;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod_nxt[r][c] = PROD_W'(vin[r]) * PROD_W'($signed(mat[r][c]));
      end
    end
  end

  always_comb begin
    res_nxt.func = func_r;
    for (int c = 0; c < 4; c++) begin
      sum_c[c] = SUM_W'(prod_r[0][c]) + SUM_W'(prod_r[1][c]) + SUM_W'(prod_r[2][c])
               + SUM_W'(prod_r[3][c]) + ROUND;
      res_nxt.dot[c] = sum_c[c][SUM_W-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else if (adv) begin
      valid_a_r <= in_valid;
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      func_r <= in_data.func;
      res_r  <= res_nxt;
    end
  end

  assign dot_valid = valid_b_r;
  assign dot_res   = res_r;

endmodule

FILE: rtl/vtpd_div.sv
// perspective divide: magnitude setup, one restoring quotient bit per stage,
// rounding and clamp of the three lanes; depends on vtpd_pkg
module vtpd_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               dot_valid,
  input  vtpd_pkg::dot_res_t dot_res,
  output logic               res_valid,
  output vtpd_pkg::out_req_t res_data
);
  import vtpd_pkg::*;

  localparam logic signed [DOT_W-1:0] NZ = DOT_W'(NEAR_ZERO);
  localparam logic [COORD_W-1:0] S32_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] S32_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [QUO_W:0] MAG_OVF = (QUO_W+1)'(1) << QUO_W;
  localparam logic [QUO_W:0] MAG_MIN = (QUO_W+1)'(1) << (COORD_W-1);

  logic [QUO_W:0]       valid_r;
  div_ctl_t             ctl_r [QUO_W+1];
  logic [DOT_W-1:0]     den_r [QUO_W+1];
  logic [REM_W-1:0]     rem_r [QUO_W+1][LANES];
  logic [QUO_W-1:0]     quo_r [QUO_W+1][LANES];
  logic [QUO_W-1:0]     low_r [QUO_W+1][LANES];

  div_ctl_t             ctl_nxt;
  logic [DOT_W-1:0]     den_nxt;
  logic [REM_W-1:0]     rem_nxt [QUO_W+1][LANES];
  logic [QUO_W-1:0]     quo_nxt [QUO_W+1][LANES];
  logic [QUO_W-1:0]     low_nxt [QUO_W+1][LANES];

  logic signed [DOT_W-1:0] w_s;
  logic signed [DOT_W-1:0] t_s;
  logic [DOT_W-1:0]        n_mag;
  logic [REM_W-1:0]        shl;
  logic                    ge;

  logic [QUO_W:0]          qp1;
  logic [QUO_W:0]          mag;
  logic [COORD_W-1:0]      lane_val [LANES];
  logic [LANES-1:0]        lane_sat;

  // setup of magnitudes and undivided clamp
  always_comb begin
    w_s         = $signed(dot_res.dot[3]);
    den_nxt     = w_s[DOT_W-1] ? DOT_W'(-w_s) : DOT_W'(w_s);
    ctl_nxt.div = dot_res.func && !((w_s < NZ) && (w_s > -NZ));
    for (int k = 0; k < LANES; k++) begin
      t_s                  = $signed(dot_res.dot[k]);
      n_mag                = t_s[DOT_W-1] ? DOT_W'(-t_s) : DOT_W'(t_s);
      ctl_nxt.neg[k]       = t_s[DOT_W-1] ^ w_s[DOT_W-1];
      ctl_nxt.ovf[k]       = DOT_W'(n_mag[DOT_W-1:FRAC_BITS]) >= den_nxt;
      ctl_nxt.clamp_sat[k] = !((&t_s[DOT_W-1:COORD_W-1]) || !(|t_s[DOT_W-1:COORD_W-1]));
      if (ctl_nxt.clamp_sat[k]) begin
        ctl_nxt.clamp_val[k] = t_s[DOT_W-1] ? S32_MIN : S32_MAX;
      end else begin
        ctl_nxt.clamp_val[k] = t_s[COORD_W-1:0];
      end
      rem_nxt[0][k] = REM_W'(n_mag[DOT_W-1:FRAC_BITS]);
      quo_nxt[0][k] = '0;
      low_nxt[0][k] = {n_mag[FRAC_BITS-1:0], {(QUO_W-FRAC_BITS){1'b0}}};
    end
    // restoring steps
    for (int s = 1; s <= QUO_W; s++) begin
      for (int k = 0; k < LANES; k++) begin
        shl = {rem_r[s-1][k][REM_W-2:0], low_r[s-1][k][QUO_W-1]};
        ge  = shl >= REM_W'(den_r[s-1]);
        rem_nxt[s][k] = ge ? (shl - REM_W'(den_r[s-1])) : shl;
        quo_nxt[s][k] = {quo_r[s-1][k][QUO_W-2:0], ge};
        low_nxt[s][k] = {low_r[s-1][k][QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[QUO_W-1:0], dot_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r[0] <= ctl_nxt;
      den_r[0] <= den_nxt;
      for (int s = 1; s <= QUO_W; s++) begin
        ctl_r[s] <= ctl_r[s-1];
        den_r[s] <= den_r[s-1];
      end
      for (int s = 0; s <= QUO_W; s++) begin
        for (int k = 0; k < LANES; k++) begin
          rem_r[s][k] <= rem_nxt[s][k];
          quo_r[s][k] <= quo_nxt[s][k];
          low_r[s][k] <= low_nxt[s][k];
        end
      end
    end
  end

  // rounding, sign and clamp
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      qp1 = {1'b0, quo_r[QUO_W][k]} + (QUO_W+1)'(1);
      mag = ctl_r[QUO_W].ovf[k] ? MAG_OVF : {1'b0, qp1[QUO_W:1]};
      if (!ctl_r[QUO_W].div) begin
        lane_val[k] = ctl_r[QUO_W].clamp_val[k];
        lane_sat[k] = ctl_r[QUO_W].clamp_sat[k];
      end else if (ctl_r[QUO_W].neg[k]) begin
        lane_sat[k] = mag > MAG_MIN;
        lane_val[k] = lane_sat[k] ? S32_MIN : COORD_W'(~mag[COORD_W-1:0] + COORD_W'(1));
      end else begin
        lane_sat[k] = mag >= MAG_MIN;
        lane_val[k] = lane_sat[k] ? S32_MAX : mag[COORD_W-1:0];
      end
    end
    res_data.out_x     = lane_val[0];
    res_data.out_y     = lane_val[1];
    res_data.out_z     = lane_val[2];
    res_data.divided   = ctl_r[QUO_W].div;
    res_data.saturated = |lane_sat;
  end

  assign res_valid = valid_r[QUO_W];

  a_div_den_ok: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[0] && ctl_r[0].div |-> den_r[0] >= DOT_W'(NEAR_ZERO))
    else $error("divide selected with near-zero w");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[QUO_W] && ctl_r[QUO_W].div && !ctl_r[QUO_W].ovf[0]
      |-> rem_r[QUO_W][0] < REM_W'(den_r[QUO_W]))
    else $error("remainder not below divisor");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[QUO_W] && ctl_r[QUO_W].div && ctl_r[QUO_W].ovf[0] |-> res_data.saturated)
    else $error("quotient overflow without saturation flag");

endmodule

FILE: rtl/vertex_transform_perspective_divide_unit.sv
// channel  | direction | handshake          | payload
// in_      | input     | in_valid/in_stall  | vtpd_pkg::in_req_t
// out_     | output    | out_valid/out_stall| vtpd_pkg::out_req_t
// cfg      | input     | psel/penable/pwrite| 64-bit matrix registers at 8*i
// one request per cycle unless stalled; stages in order: product and sum stages, divide
// setup, 33 restoring quotient stages, then the output register
// the whole pipeline advances together; out_stall with a pending result holds it
// synchronous active-low reset clears the valid bits and loads the identity matrix
// depends on vtpd_pkg, vtpd_cfg_regs, vtpd_dot, vtpd_div
module vertex_transform_perspective_divide_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  vtpd_pkg::in_req_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output vtpd_pkg::out_req_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vtpd_pkg::ADDR_W-1:0] paddr,
  input  logic [vtpd_pkg::DATA_W-1:0] pwdata,
  output logic [vtpd_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import vtpd_pkg::*;

  mat_t     mat;
  logic     adv;
  logic     dot_valid;
  dot_res_t dot_res;
  logic     res_valid;
  out_req_t res_data;
  logic     out_valid_r;
  out_req_t out_data_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  vtpd_cfg_regs u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .mat
  );

  vtpd_dot u_dot (
    .clk, .rst_n, .adv, .in_valid, .in_data, .mat, .dot_valid, .dot_res
  );

  vtpd_div u_div (
    .clk, .rst_n, .adv, .dot_valid, .dot_res, .res_valid, .res_data
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
